/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PLSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also runs during reset
`define PLSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* src/plsu_pkg.sv */
package plsu_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int IDX_W     = 7;
    localparam int CNT_W     = 7;
    localparam int WORD_W    = 32;

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_FRONT  = 3'd1,
        MODE_BACK   = 3'd2,
        MODE_AT     = 3'd3,
        MODE_DELETE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]              mode;
        logic [IDX_W-1:0]        index;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic                     read_valid;
        logic [1:0]               status;
        logic [CNT_W-1:0]         entry_count;
    } t_rsp;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              shift_up;
        logic              shift_dn;
        logic              load_lane;
        logic              hold_lane;
        logic [IDX_W-1:0]  pos;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

endpackage

/* src/plsu_if.sv */
interface plsu_req_if;
    import plsu_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plsu_rsp_if;
    import plsu_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/positional_list_store_unit.sv */
// channel   dir   modport  payload
// i_req     in    sink     mode, index, value
// o_rsp     out   source   read_value, read_valid, status, entry_count
//
// one request at a time: transfer in, an execute step, then a read scan for reads
// insert, delete and misses: the result is registered at the end of the execute step (cells shift
//   in parallel), and the next transfer in waits until the unit is back in idle
// read at position k: the execute step loads every entry into the read lane, and the word walks
//   k cells down the read lane of the cell chain to cell zero
// i_rst_n (synchronous, active low) clears control and the entry count; cells are not reset
// a stalled result holds the unit in its last step and the read lane in place; the next
// request is taken while a finished result waits on o_rsp
module positional_list_store_unit #(
    parameter int DEPTH = plsu_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plsu_req_if.sink    i_req,
    plsu_rsp_if.source  o_rsp
);
    import plsu_pkg::*;
    `include "assert_macros.svh"

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_req              r_req;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W-1:0]  r_steps;
    logic [IDX_W-1:0]  n_steps;
    logic              r_out_valid;
    logic              n_out_valid;
    t_rsp              r_out;
    t_rsp              n_out;

    t_cell_ctl         w_ctl;
    logic              w_out_free;
    logic              w_finish;
    logic              w_accept;
    logic [WORD_W-1:0] w_entry [DEPTH];
    logic [WORD_W-1:0] w_lane  [DEPTH];

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept = i_req.valid && i_req.ready;

    // request decode and sequencing
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_steps  = r_steps;
        w_finish = 1'b0;
        n_out    = r_out;
        w_ctl    = '0;
        w_ctl.word = r_req.value;

        n_out.read_value  = '1;
        n_out.read_valid  = 1'b0;
        n_out.status      = ST_DONE;
        n_out.entry_count = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.mode) inside
                    MODE_READ: begin
                        if (r_req.index < r_count) begin
                            w_ctl.load_lane = 1'b1;
                            n_steps = r_req.index;
                            n_state = S_SCAN;
                        end else begin
                            n_out.status = ST_RANGE;
                            w_finish = w_out_free;
                        end
                    end
                    MODE_FRONT, MODE_BACK: begin
                        w_finish = w_out_free;
                        if (r_count >= FULL_CNT) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl.shift_up = w_out_free;
                            w_ctl.pos = (r_req.mode == MODE_FRONT) ? '0 : r_count;
                            n_count = r_count + 1'b1;
                        end
                    end
                    MODE_AT: begin
                        w_finish = w_out_free;
                        if (r_req.index > r_count) begin
                            n_out.status = ST_RANGE;
                        end else if (r_count >= FULL_CNT) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl.shift_up = w_out_free;
                            w_ctl.pos = r_req.index;
                            n_count = r_count + 1'b1;
                        end
                    end
                    MODE_DELETE: begin
                        w_finish = w_out_free;
                        if (r_req.index >= r_count) begin
                            n_out.status = ST_RANGE;
                        end else begin
                            w_ctl.shift_dn = w_out_free;
                            w_ctl.pos = r_req.index;
                            n_count = r_count - 1'b1;
                        end
                    end
                    default: begin
                        // unused modes complete with no effect
                        w_finish = w_out_free;
                    end
                endcase
                if (!w_out_free) begin
                    n_count = r_count;
                end
                n_out.entry_count = n_count;
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // read lane advances one cell per cycle until the word reaches cell zero
                if (r_steps != '0) begin
                    n_steps = r_steps - 1'b1;
                end else begin
                    // word sits in cell zero, keep it there while the result stalls
                    w_ctl.hold_lane = 1'b1;
                    n_out.read_value = w_lane[0];
                    n_out.read_valid = 1'b1;
                    w_finish = w_out_free;
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (!w_finish) begin
            n_out = r_out;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.data;
        end
        r_steps <= n_steps;
        r_out   <= n_out;
    end

    // chain of cells, each holding one list position
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_left;
        logic [WORD_W-1:0] w_right;
        logic [WORD_W-1:0] w_rlane;

        if (g == 0) begin : g_first
            assign w_left = w_entry[g];
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
            assign w_rlane = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
            assign w_rlane = w_lane[g+1];
        end

        plsu_cell #(
            .POS (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_right_lane  (w_rlane),
            .o_entry       (w_entry[g]),
            .o_lane        (w_lane[g])
        );
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // count stays within the chain
    `PLSU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "count above depth")
    // count moves only in the execute step
    `PLSU_ASSERT(a_count_hold, i_clk, i_rst_n, (r_state != S_EXEC) |=> $stable(r_count), "count moved")
    // a read scan only walks to a position inside the list
    `PLSU_ASSERT(a_scan_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_steps < r_count), "bad scan")
    // a transfer in always leads to the execute step
    `PLSU_ASSERT(a_accept_exec, i_clk, i_rst_n, w_accept |=> (r_state == S_EXEC), "no execute step")
    // cells never see insert and delete together
    `PLSU_ASSERT_ALWAYS(a_ctl_excl, i_clk, !(w_ctl.shift_up && w_ctl.shift_dn), "shift clash")

endmodule

/* src/plsu_cell.sv */
module plsu_cell #(
    parameter int POS = 0
) (
    input  logic                          i_clk,
    input  plsu_pkg::t_cell_ctl           i_ctl,
    input  logic [plsu_pkg::WORD_W-1:0]   i_left_entry,
    input  logic [plsu_pkg::WORD_W-1:0]   i_right_entry,
    input  logic [plsu_pkg::WORD_W-1:0]   i_right_lane,
    output logic [plsu_pkg::WORD_W-1:0]   o_entry,
    output logic [plsu_pkg::WORD_W-1:0]   o_lane
);
    import plsu_pkg::*;

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

    logic [WORD_W-1:0] r_entry;
    logic [WORD_W-1:0] n_entry;
    logic [WORD_W-1:0] r_lane;
    logic [WORD_W-1:0] n_lane;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up) begin
            if (MY_POS > i_ctl.pos) begin
                n_entry = i_left_entry;
            end else if (MY_POS == i_ctl.pos) begin
                n_entry = i_ctl.word;
            end
        end else if (i_ctl.shift_dn) begin
            if (MY_POS >= i_ctl.pos) begin
                n_entry = i_right_entry;
            end
        end
    end

    // read lane: parallel load, then moves one cell toward position zero per cycle
    // unless held while the result waits
    always_comb begin
        if (i_ctl.load_lane) begin
            n_lane = r_entry;
        end else if (i_ctl.hold_lane) begin
            n_lane = r_lane;
        end else begin
            n_lane = i_right_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_lane  <= n_lane;
    end

    assign o_entry = r_entry;
    assign o_lane  = r_lane;

endmodule
